@@ rtl/mvm_pkg.sv @@
// shared types and constants of the matrix-vector multiply unit
package mvm_pkg;

	localparam int IDX_W  = 6;   // row, column and vector index width
	localparam int CNT_W  = 7;   // used-count width, holds 1..64
	localparam int VAL_W  = 16;  // signed Q4.12 element
	localparam int PROD_W = 32;  // signed Q8.24 product
	localparam int SUM_W  = 40;  // signed Q16.24 sum
	localparam int CNT_CAP = 64; // longest result burst
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	// register index, taken from paddr bit 2
	localparam logic REG_ROWS_USED = 1'b0;
	localparam logic REG_COLS_USED = 1'b1;

	typedef enum logic [1:0] {
		ACT_WR_MAT = 2'd0,
		ACT_WR_VEC = 2'd1,
		ACT_MV     = 2'd2,
		ACT_VM     = 2'd3
	} action_t;

	// controller to datapath
	typedef struct packed {
		logic             mat_we;
		logic             vec_we;
		logic             valid;  // one multiply-accumulate this cycle
		logic             first;  // clear the accumulator
		logic             emit;   // final term of this result
		logic             last;   // final result of the burst
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] vidx;
	} mvm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_busy;
	} mvm_stat_t;

endpackage

@@ rtl/mvm_ctrl.sv @@
// sequencer of the matrix-vector multiply unit: accepts items, walks the index space
module mvm_ctrl
	import mvm_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       action,
	input  logic [CNT_W-1:0] rows_used,
	input  logic [CNT_W-1:0] cols_used,
	input  mvm_stat_t        stat,
	output logic             busy,
	output mvm_cmd_t         cmd
);

	localparam int ROW_LIM = (MAX_ROWS < CNT_CAP) ? MAX_ROWS : CNT_CAP;
	localparam int COL_LIM = (MAX_COLS < CNT_CAP) ? MAX_COLS : CNT_CAP;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t           state_q;
	logic             vm_q;
	logic [IDX_W-1:0] outer_q;
	logic [IDX_W-1:0] inner_q;
	logic [IDX_W-1:0] outer_end_q;
	logic [IDX_W-1:0] inner_end_q;

	logic             accept;
	action_t          act;
	logic [CNT_W-1:0] nr;
	logic [CNT_W-1:0] nc;
	logic [IDX_W-1:0] nr_end;
	logic [IDX_W-1:0] nc_end;

	assign act    = action_t'(action);
	assign busy   = (state_q != ST_IDLE) || stat.pipe_busy;
	assign accept = start && !busy;

	// zero counts as one, clamp to store size
	always_comb begin
		if (rows_used == '0)
			nr = CNT_W'(1);
		else if (32'(rows_used) > ROW_LIM)
			nr = CNT_W'(ROW_LIM);
		else
			nr = rows_used;
		if (cols_used == '0)
			nc = CNT_W'(1);
		else if (32'(cols_used) > COL_LIM)
			nc = CNT_W'(COL_LIM);
		else
			nc = cols_used;
		nr_end = IDX_W'(nr - CNT_W'(1));
		nc_end = IDX_W'(nc - CNT_W'(1));
	end

	always_comb begin
		cmd        = '0;
		cmd.mat_we = accept && (act == ACT_WR_MAT);
		cmd.vec_we = accept && (act == ACT_WR_VEC);
		cmd.valid  = (state_q == ST_RUN);
		cmd.first  = (inner_q == '0);
		cmd.emit   = (inner_q == inner_end_q);
		cmd.last   = (outer_q == outer_end_q);
		cmd.idx    = outer_q;
		cmd.row    = vm_q ? inner_q : outer_q;
		cmd.col    = vm_q ? outer_q : inner_q;
		cmd.vidx   = inner_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vm_q        <= 1'b0;
			outer_q     <= '0;
			inner_q     <= '0;
			outer_end_q <= '0;
			inner_end_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (act == ACT_MV || act == ACT_VM)) begin
						state_q <= ST_RUN;
						vm_q    <= (act == ACT_VM);
						outer_q <= '0;
						inner_q <= '0;
						// m*v: outer over rows, inner over columns; v*m the other way
						outer_end_q <= (act == ACT_VM) ? nc_end : nr_end;
						inner_end_q <= (act == ACT_VM) ? nr_end : nc_end;
					end
				end
				ST_RUN: begin
					if (inner_q == inner_end_q) begin
						inner_q <= '0;
						if (outer_q == outer_end_q)
							state_q <= ST_IDLE;
						else
							outer_q <= outer_q + IDX_W'(1);
					end else begin
						inner_q <= inner_q + IDX_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/mvm_datapath.sv @@
// stores, multiplier and accumulator of the matrix-vector multiply unit
module mvm_datapath
	import mvm_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mvm_cmd_t                cmd,
	input  logic [IDX_W-1:0]        row,
	input  logic [IDX_W-1:0]        col,
	input  logic [IDX_W-1:0]        vec_index,
	input  logic signed [VAL_W-1:0] value,
	output mvm_stat_t               stat,
	output logic                    out_valid,
	output logic [IDX_W-1:0]        out_index,
	output logic signed [SUM_W-1:0] out_value,
	output logic                    last
);

	localparam int VEC_DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
	localparam int VEC_AW    = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;

	logic signed [VAL_W-1:0] mat_mem [MAT_DEPTH];
	logic signed [VAL_W-1:0] vec_mem [VEC_DEPTH];

	logic [MAT_AW-1:0] wr_addr;
	logic [MAT_AW-1:0] rd_addr;
	logic              mat_wr_ok;
	logic              vec_wr_ok;

	// stage 1: addresses
	logic              v_s1, first_s1, emit_s1, last_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [MAT_AW-1:0] mat_addr_s1;
	logic [VEC_AW-1:0] vec_addr_s1;
	// stage 2: store read data
	logic                    v_s2, first_s2, emit_s2, last_s2;
	logic [IDX_W-1:0]        idx_s2;
	logic signed [VAL_W-1:0] mat_rd_s2;
	logic signed [VAL_W-1:0] vec_rd_s2;
	// stage 3: product
	logic                     v_s3, first_s3, emit_s3, last_s3;
	logic [IDX_W-1:0]         idx_s3;
	logic signed [PROD_W-1:0] prod_s3;

	logic signed [SUM_W-1:0] acc_q;
	logic signed [SUM_W-1:0] sum_next;

	assign wr_addr   = MAT_AW'(32'(row) * 32'(MAX_COLS) + 32'(col));
	assign rd_addr   = MAT_AW'(32'(cmd.row) * 32'(MAX_COLS) + 32'(cmd.col));
	assign mat_wr_ok = (32'(row) < 32'(MAX_ROWS)) && (32'(col) < 32'(MAX_COLS));
	assign vec_wr_ok = 32'(vec_index) < 32'(VEC_DEPTH);

	always_ff @(posedge clk) begin
		if (cmd.mat_we && mat_wr_ok)
			mat_mem[wr_addr] <= value;
		mat_rd_s2 <= mat_mem[mat_addr_s1];
	end

	always_ff @(posedge clk) begin
		if (cmd.vec_we && vec_wr_ok)
			vec_mem[VEC_AW'(vec_index)] <= value;
		vec_rd_s2 <= vec_mem[vec_addr_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= cmd.valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3 && emit_s3;
		end
	end

	assign sum_next = (first_s3 ? SUM_W'(0) : acc_q) + SUM_W'(prod_s3);

	always_ff @(posedge clk) begin
		first_s1    <= cmd.first;
		emit_s1     <= cmd.emit;
		last_s1     <= cmd.last;
		idx_s1      <= cmd.idx;
		mat_addr_s1 <= rd_addr;
		vec_addr_s1 <= VEC_AW'(cmd.vidx);

		first_s2 <= first_s1;
		emit_s2  <= emit_s1;
		last_s2  <= last_s1;
		idx_s2   <= idx_s1;

		first_s3 <= first_s2;
		emit_s3  <= emit_s2;
		last_s3  <= last_s2;
		idx_s3   <= idx_s2;
		prod_s3  <= mat_rd_s2 * vec_rd_s2;

		if (v_s3)
			acc_q <= sum_next;
		if (v_s3 && emit_s3) begin
			out_index <= idx_s3;
			out_value <= sum_next;
			last      <= last_s3;
		end
	end

	assign stat.pipe_busy = v_s1 || v_s2 || v_s3;

endmodule

@@ rtl/matrix_vector_multiply_unit.sv @@
// top level of the matrix-vector multiply unit: register port, sequencer and datapath
//
// a write item (action 0 or 1) stores one matrix or vector element and does not
// raise busy, so writes go in back to back; a compute item (action 2 for m*v, action 3
// for v*m) walks rows_used * cols_used multiply-accumulate steps, one a cycle through
// the single multiplier and the one read port of each store, and busy stays high from
// acceptance until the last step leaves the pipeline; results come out in index order
// as single-cycle out_valid strobes with last on the final one and cannot be held
// off, so the receiver must take each transaction as it appears; elements are
// signed q4.12 and sums are exact signed q16.24 in 40 bits; matrix and vector stores
// come up undefined and must be written before they are used
module matrix_vector_multiply_unit
	import mvm_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// item port
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              action,
	input  logic [IDX_W-1:0]        row,
	input  logic [IDX_W-1:0]        col,
	input  logic [IDX_W-1:0]        vec_index,
	input  logic signed [VAL_W-1:0] value,
	// result port
	output logic                    out_valid,
	output logic [IDX_W-1:0]        out_index,
	output logic signed [SUM_W-1:0] out_value,
	output logic                    last,
	// register port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [CFG_AW-1:0]       paddr,
	input  logic [CFG_DW-1:0]       pwdata,
	output logic [CFG_DW-1:0]       prdata,
	output logic                    pready
);

	logic [CNT_W-1:0] rows_used_q;
	logic [CNT_W-1:0] cols_used_q;
	logic             cfg_wr;
	mvm_cmd_t         cmd;
	mvm_stat_t        stat;

	// register transaction completes in its access cycle, no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_used_q <= CNT_W'(CNT_CAP);
			cols_used_q <= CNT_W'(CNT_CAP);
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_ROWS_USED: rows_used_q <= pwdata[CNT_W-1:0];
				REG_COLS_USED: cols_used_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ROWS_USED: prdata = CFG_DW'(rows_used_q);
			REG_COLS_USED: prdata = CFG_DW'(cols_used_q);
			default:       prdata = '0;
		endcase
	end

	// sequencer: takes items, counts through rows and columns
	mvm_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.rows_used (rows_used_q),
		.cols_used (cols_used_q),
		.stat      (stat),
		.busy      (busy),
		.cmd       (cmd)
	);

	// stores, multiplier, accumulator and result register
	mvm_datapath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.row       (row),
		.col       (col),
		.vec_index (vec_index),
		.value     (value),
		.stat      (stat),
		.out_valid (out_valid),
		.out_index (out_index),
		.out_value (out_value),
		.last      (last)
	);

	// a write transaction never makes the block busy
	a_write_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (action == ACT_WR_MAT || action == ACT_WR_VEC) |=> !busy)
		else $error("write item left the block busy");

	// while results of a burst remain, the block stays busy
	a_burst_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> busy)
		else $error("block idle with results still pending");

	// a result only follows work in progress
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(busy))
		else $error("result without a compute in progress");

endmodule
